// ===== sv/gmrc_pkg.sv =====
// ---------------------------------------------------------------------------
// gmrc_pkg
// Shared types, codes and the sine table of the grid maze ray caster.
// ---------------------------------------------------------------------------
package gmrc_pkg;

    localparam int POS_W          = 13;
    localparam int ANGLE_W        = 9;
    localparam int OUT_W          = 13;
    localparam int OFF_W          = 6;
    localparam int CODE_W         = 2;
    localparam int WALLS_W        = 8;
    localparam int INDEX_W        = 8;
    localparam int FIELD_MAX      = 8191;
    localparam int SINE_W         = 16;
    localparam int TRIG_MAG_W     = 15;
    localparam int SINE_ONE_SHIFT = 14;
    localparam int FULL_TURN      = 360;
    localparam int QUARTER_TURN   = 90;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_VIEW  = 1'b1;

    localparam logic [1:0] SIDE_N = 2'd0;
    localparam logic [1:0] SIDE_S = 2'd1;
    localparam logic [1:0] SIDE_W = 2'd2;
    localparam logic [1:0] SIDE_E = 2'd3;

    typedef struct packed {
        logic load_view;
        logic maze_write;
        logic clear_write;
        logic ray_setup;
        logic xing_eval;
        logic mul;
        logic div_off;
        logic other_eval;
        logic ram_read;
        logic div_dist;
        logic merge;
        logic out_load;
    } gmrc_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic off_grid;
        logic out_free;
    } gmrc_sts_t;

    // round(16384*sin(d)) for d = 0..90
    function automatic logic [TRIG_MAG_W-1:0] sine_mag(input logic [6:0] d);
        logic [TRIG_MAG_W-1:0] v;
        begin
            case (d)
                7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
                7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
                7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
                7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
                7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
                7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
                7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
                7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
                7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
                7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
                7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
                7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
                7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
                7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
                7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
                7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
                7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
                7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
                7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
                7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
                7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
                7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
                7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
                7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
                7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
                7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
                7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
                7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
                7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
                7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
                7'd90: v = 15'd16384;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

    // Signed Q1.14 sine of an angle in 0..359 degrees, folded by quadrant
    function automatic logic signed [SINE_W-1:0] sine_deg(input logic [ANGLE_W-1:0] a);
        logic [TRIG_MAG_W-1:0] m;
        logic                  neg;
        begin
            if (a <= 9'd90)
            begin
                m   = sine_mag(7'(a));
                neg = 1'b0;
            end
            else if (a <= 9'd180)
            begin
                m   = sine_mag(7'(9'd180 - a));
                neg = 1'b0;
            end
            else if (a <= 9'd270)
            begin
                m   = sine_mag(7'(a - 9'd180));
                neg = 1'b1;
            end
            else
            begin
                m   = sine_mag(7'(9'd360 - a));
                neg = 1'b1;
            end
            return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    endfunction

    function automatic logic [CODE_W-1:0] wall_field(input logic [WALLS_W-1:0] b,
                                                     input logic [1:0] side);
        logic [CODE_W-1:0] v;
        begin
            unique case (side)
                SIDE_N:  v = b[7:6];
                SIDE_S:  v = b[3:2];
                SIDE_W:  v = b[1:0];
                SIDE_E:  v = b[5:4];
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== sv/gmrc_ram.sv =====
// ---------------------------------------------------------------------------
// gmrc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gmrc_div.sv =====
// ---------------------------------------------------------------------------
// gmrc_div
// Unsigned restoring divider, several quotient bits per cycle.
// ---------------------------------------------------------------------------
module gmrc_div #(
    parameter int NUM_W          = 28,
    parameter int DEN_W          = 15,
    parameter int BITS_PER_CYCLE = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int STEPS = (NUM_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W = STEPS * BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [PAD_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            r = {r[DEN_W-1:0], q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r    = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= PAD_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg[NUM_W-1:0];
    assign done = (cnt_reg == '0);

endmodule

// ===== sv/gmrc_ctrl.sv =====
// ---------------------------------------------------------------------------
// gmrc_ctrl
// Sequencer: clearing pass, request intake, ray and grid-line stepping.
// ---------------------------------------------------------------------------
module gmrc_ctrl #(
    parameter int GRID_SIDE      = 16,
    parameter int HALF_FIELD_DEG = 30
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        req_valid,
    output logic                                        req_stall,
    input  logic                                        command,
    input  gmrc_pkg::gmrc_sts_t                         sts,
    output gmrc_pkg::gmrc_cmd_t                         cmd,
    output logic [$clog2(2*HALF_FIELD_DEG+1)-1:0]      ray,
    output logic [$clog2(GRID_SIDE+1)-1:0]              line,
    output logic                                        kind,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]      clr_addr
);

    import gmrc_pkg::*;

    localparam int RW         = $clog2(2*HALF_FIELD_DEG+1);
    localparam int GW         = $clog2(GRID_SIDE+1);
    localparam int AW         = $clog2(GRID_SIDE*GRID_SIDE);
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RAY   = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIVO  = 4'd5;
    localparam logic [3:0] S_WOFF  = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_WDIST = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [RW-1:0] ray_reg, ray_next;
    logic [GW-1:0] line_reg, line_next;
    logic          kind_reg, kind_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          do_step;

    always_comb
    begin
        state_next = state_reg;
        ray_next   = ray_reg;
        line_next  = line_reg;
        kind_next  = kind_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        do_step    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (command == CMD_VIEW)
                    begin
                        cmd.load_view = 1'b1;
                        ray_next      = '0;
                        state_next    = S_RAY;
                    end
                    else
                    begin
                        cmd.maze_write = 1'b1;
                    end
                end
            end
            S_RAY:
            begin
                cmd.ray_setup = 1'b1;
                line_next     = '0;
                kind_next     = 1'b0;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.xing_eval = 1'b1;
                if (sts.skip)
                begin
                    do_step = 1'b1;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVO;
            end
            S_DIVO:
            begin
                cmd.div_off = 1'b1;
                state_next  = S_WOFF;
            end
            S_WOFF:
            begin
                if (sts.div_done)
                begin
                    cmd.other_eval = 1'b1;
                    state_next     = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.off_grid)
                begin
                    do_step = 1'b1;
                end
                else
                begin
                    cmd.ram_read = 1'b1;
                    cmd.div_dist = 1'b1;
                    state_next   = S_WDIST;
                end
            end
            S_WDIST:
            begin
                if (sts.div_done)
                begin
                    cmd.merge = 1'b1;
                    do_step   = 1'b1;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (ray_reg == RW'(2*HALF_FIELD_DEG))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ray_next   = ray_reg + 1'b1;
                        state_next = S_RAY;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next grid line, horizontal before vertical
        if (do_step)
        begin
            if (!kind_reg)
            begin
                kind_next  = 1'b1;
                state_next = S_EVAL;
            end
            else if (line_reg == GW'(GRID_SIDE))
            begin
                state_next = S_OUT;
            end
            else
            begin
                line_next  = line_reg + 1'b1;
                kind_next  = 1'b0;
                state_next = S_EVAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ray_reg   <= '0;
            line_reg  <= '0;
            kind_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ray_reg   <= ray_next;
            line_reg  <= line_next;
            kind_reg  <= kind_next;
            clr_reg   <= clr_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign ray       = ray_reg;
    assign line      = line_reg;
    assign kind      = kind_reg;
    assign clr_addr  = clr_reg;

endmodule

// ===== sv/gmrc_dp.sv =====
// ---------------------------------------------------------------------------
// gmrc_dp
// Datapath: maze store, trig setup, crossing arithmetic, merge, result stage.
// ---------------------------------------------------------------------------
module gmrc_dp #(
    parameter int GRID_SIDE      = 16,
    parameter int HALF_FIELD_DEG = 30,
    parameter int FRAC_BITS      = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  gmrc_pkg::gmrc_cmd_t                         cmd,
    output gmrc_pkg::gmrc_sts_t                         sts,
    input  logic [$clog2(2*HALF_FIELD_DEG+1)-1:0]      ray,
    input  logic [$clog2(GRID_SIDE+1)-1:0]              line,
    input  logic                                        kind,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]      clr_addr,
    input  logic [gmrc_pkg::INDEX_W-1:0]                cell_index,
    input  logic [gmrc_pkg::WALLS_W-1:0]                cell_walls,
    input  logic [gmrc_pkg::POS_W-1:0]                  pos_x,
    input  logic [gmrc_pkg::POS_W-1:0]                  pos_y,
    input  logic [gmrc_pkg::ANGLE_W-1:0]                view_angle,
    input  logic                                        rsp_stall,
    output logic                                        rsp_valid,
    output logic signed [gmrc_pkg::OFF_W-1:0]           ray_offset,
    output logic [gmrc_pkg::OUT_W-1:0]                  hit_x,
    output logic [gmrc_pkg::OUT_W-1:0]                  hit_y,
    output logic [gmrc_pkg::OUT_W-1:0]                  hit_distance,
    output logic [1:0]                                  hit_side,
    output logic [gmrc_pkg::CODE_W-1:0]                 wall_code,
    output logic                                        last_ray
);

    import gmrc_pkg::*;

    localparam int RW         = $clog2(2*HALF_FIELD_DEG+1);
    localparam int GW         = $clog2(GRID_SIDE+1);
    localparam int CW         = $clog2(GRID_SIDE);
    localparam int AW         = $clog2(GRID_SIDE*GRID_SIDE);
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int LCW        = GW + FRAC_BITS;
    localparam int XW         = LCW;
    localparam int MW         = (LCW > POS_W) ? LCW : POS_W;
    localparam int NW         = MW + TRIG_MAG_W;
    localparam int OW         = NW + 2;
    localparam logic signed [OW-1:0] OTHER_LIM = OW'(GRID_SIDE * (1 << FRAC_BITS));

    typedef struct packed {
        logic [NW-1:0]     reach;
        logic              kind;
        logic [GW-1:0]     line;
        logic [XW-1:0]     x;
        logic [XW-1:0]     y;
        logic [1:0]        side;
        logic [CODE_W-1:0] code;
    } xing_t;

    function automatic logic key_before(input xing_t a, input xing_t b);
        return (a.reach < b.reach) ||
               ((a.reach == b.reach) &&
                ((a.kind < b.kind) || ((a.kind == b.kind) && (a.line < b.line))));
    endfunction

    function automatic logic [OUT_W-1:0] sat_coord(input logic [XW-1:0] v);
        logic [XW+OUT_W-1:0] w;
        begin
            w = {{OUT_W{1'b0}}, v};
            return (w > (XW+OUT_W)'(FIELD_MAX)) ? OUT_W'(FIELD_MAX) : OUT_W'(v);
        end
    endfunction

    // ---- view capture and trig setup ----
    logic [POS_W-1:0]          px_reg, py_reg;
    logic [ANGLE_W-1:0]        view_reg;
    logic signed [SINE_W-1:0]  s_reg, s_next, c_reg, c_next;
    logic [10:0]               ang_sum;
    logic [ANGLE_W-1:0]        ang;
    logic [ANGLE_W:0]          ang90;

    always_comb
    begin
        ang_sum = 11'(view_reg) + 11'(FULL_TURN) + 11'(ray) - 11'(HALF_FIELD_DEG);
        if (ang_sum >= 11'(2*FULL_TURN))
        begin
            ang = ANGLE_W'(ang_sum - 11'(2*FULL_TURN));
        end
        else if (ang_sum >= 11'(FULL_TURN))
        begin
            ang = ANGLE_W'(ang_sum - 11'(FULL_TURN));
        end
        else
        begin
            ang = ANGLE_W'(ang_sum);
        end
        ang90 = {1'b0, ang} + 10'(QUARTER_TURN);
        if (ang90 >= 10'(FULL_TURN))
        begin
            ang90 = ang90 - 10'(FULL_TURN);
        end
        s_next = sine_deg(ang);
        c_next = sine_deg(ANGLE_W'(ang90));
    end

    // ---- crossing evaluation ----
    logic [POS_W-1:0]         p_norm, p_other;
    logic signed [SINE_W-1:0] n_comp, t_comp;
    logic [LCW-1:0]           lc;
    logic signed [MW:0]       d;
    logic                     ahead;
    logic [MW-1:0]            mag_reg, mag_next;
    logic [TRIG_MAG_W-1:0]    an_reg, an_next, at_reg, at_next;
    logic                     t_neg_reg, n_pos_reg;
    logic [POS_W-1:0]         p_other_reg;
    logic [NW-1:0]            prod_reg;

    always_comb
    begin
        p_norm  = kind ? px_reg : py_reg;
        p_other = kind ? py_reg : px_reg;
        n_comp  = kind ? c_reg : s_reg;
        t_comp  = kind ? s_reg : c_reg;
        lc      = {line, {FRAC_BITS{1'b0}}};
        d       = $signed({1'b0, MW'(lc)}) - $signed({1'b0, MW'(p_norm)});
        ahead   = (n_comp != '0) && ((d == '0) || (d[MW] == n_comp[SINE_W-1]));
        mag_next = d[MW] ? MW'(-d) : MW'(d);
        an_next  = n_comp[SINE_W-1] ? TRIG_MAG_W'(-n_comp) : TRIG_MAG_W'(n_comp);
        at_next  = t_comp[SINE_W-1] ? TRIG_MAG_W'(-t_comp) : TRIG_MAG_W'(t_comp);
    end

    // ---- shared divider ----
    logic [NW-1:0] div_num, quo;
    logic          div_done;

    assign div_num = cmd.div_off ? prod_reg : NW'({mag_reg, {SINE_ONE_SHIFT{1'b0}}});

    gmrc_div #(
        .NUM_W          (NW),
        .DEN_W          (TRIG_MAG_W),
        .BITS_PER_CYCLE (4)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_off | cmd.div_dist),
        .num   (div_num),
        .den   (an_reg),
        .quo   (quo),
        .done  (div_done)
    );

    // ---- other coordinate, cell address, side ----
    logic signed [OW-1:0] other;
    logic                 in_range, nidx_ok;
    logic [CW-1:0]        along, nidx, row, col;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [XW-1:0]        x_reg, x_next, y_reg, y_next;
    logic [1:0]           side_reg, side_next;
    logic                 off_grid_reg;

    always_comb
    begin
        other    = t_neg_reg ? $signed(OW'(p_other_reg)) - $signed(OW'(quo))
                             : $signed(OW'(p_other_reg)) + $signed(OW'(quo));
        in_range = !other[OW-1] && (other < OTHER_LIM);
        along    = other[FRAC_BITS +: CW];
        nidx_ok  = n_pos_reg ? (line != '0) : (line != GW'(GRID_SIDE));
        nidx     = n_pos_reg ? CW'(line - 1'b1) : CW'(line);
        row      = kind ? along : nidx;
        col      = kind ? nidx : along;
        addr_next = AW'(AW'(row) * AW'(GRID_SIDE) + AW'(col));
        x_next   = kind ? lc : XW'(other);
        y_next   = kind ? XW'(other) : lc;
        if (kind)
        begin
            side_next = n_pos_reg ? SIDE_E : SIDE_W;
        end
        else
        begin
            side_next = n_pos_reg ? SIDE_N : SIDE_S;
        end
    end

    // ---- maze store ----
    logic                 idx_ok, ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WALLS_W-1:0]   ram_wdata, ram_rdata;

    assign idx_ok    = (32'(cell_index) < CELL_COUNT);
    assign ram_we    = cmd.clear_write | (cmd.maze_write & idx_ok);
    assign ram_waddr = cmd.clear_write ? clr_addr : AW'(cell_index);
    assign ram_wdata = cmd.clear_write ? '0 : cell_walls;

    gmrc_ram #(
        .WIDTH (WALLS_W),
        .DEPTH (CELL_COUNT)
    ) u_maze (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_read),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ---- nearest walled and farthest crossing ----
    xing_t cand, hit_reg, last_reg, res;
    logic  have_hit_reg, have_last_reg;

    always_comb
    begin
        cand.reach = quo;
        cand.kind  = kind;
        cand.line  = line;
        cand.x     = x_reg;
        cand.y     = y_reg;
        cand.side  = side_reg;
        cand.code  = wall_field(ram_rdata, side_reg);
    end

    // ---- result stage ----
    logic                    out_valid_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [OUT_W-1:0]        hx_reg, hx_next, hy_reg, hy_next, hd_reg, hd_next;
    logic [1:0]              hs_reg;
    logic [CODE_W-1:0]       hc_reg;
    logic                    last_reg_flag;
    logic                    out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        res = have_hit_reg ? hit_reg : last_reg;
        if (have_hit_reg || have_last_reg)
        begin
            hx_next = sat_coord(res.x);
            hy_next = sat_coord(res.y);
            hd_next = (res.reach > NW'(FIELD_MAX)) ? OUT_W'(FIELD_MAX) : OUT_W'(res.reach);
        end
        else
        begin
            // nothing ahead: report the viewer position
            hx_next = px_reg;
            hy_next = py_reg;
            hd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_hit_reg  <= 1'b0;
            have_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ray_setup)
            begin
                have_hit_reg  <= 1'b0;
                have_last_reg <= 1'b0;
            end
            else if (cmd.merge)
            begin
                if ((cand.code != '0) && (!have_hit_reg || key_before(cand, hit_reg)))
                begin
                    have_hit_reg <= 1'b1;
                end
                if (!have_last_reg || key_before(last_reg, cand))
                begin
                    have_last_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_view)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            view_reg <= view_angle;
        end
        if (cmd.ray_setup)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
        if (cmd.xing_eval)
        begin
            mag_reg     <= mag_next;
            an_reg      <= an_next;
            at_reg      <= at_next;
            t_neg_reg   <= t_comp[SINE_W-1];
            n_pos_reg   <= !n_comp[SINE_W-1];
            p_other_reg <= p_other;
        end
        if (cmd.mul)
        begin
            prod_reg <= NW'(mag_reg) * NW'(at_reg);
        end
        if (cmd.other_eval)
        begin
            addr_reg     <= addr_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            side_reg     <= side_next;
            off_grid_reg <= !(in_range && nidx_ok);
        end
        if (cmd.merge)
        begin
            if ((cand.code != '0) && (!have_hit_reg || key_before(cand, hit_reg)))
            begin
                hit_reg <= cand;
            end
            if (!have_last_reg || key_before(last_reg, cand))
            begin
                last_reg <= cand;
            end
        end
        if (cmd.out_load)
        begin
            off_reg       <= OFF_W'(int'(ray) - HALF_FIELD_DEG);
            hx_reg        <= hx_next;
            hy_reg        <= hy_next;
            hd_reg        <= hd_next;
            hs_reg        <= (have_hit_reg || have_last_reg) ? res.side : SIDE_N;
            hc_reg        <= have_hit_reg ? res.code : '0;
            last_reg_flag <= (ray == RW'(2*HALF_FIELD_DEG));
        end
    end

    assign sts.skip     = !ahead;
    assign sts.div_done = div_done;
    assign sts.off_grid = off_grid_reg;
    assign sts.out_free = out_free;

    assign rsp_valid    = out_valid_reg;
    assign ray_offset   = off_reg;
    assign hit_x        = hx_reg;
    assign hit_y        = hy_reg;
    assign hit_distance = hd_reg;
    assign hit_side     = hs_reg;
    assign wall_code    = hc_reg;
    assign last_ray     = last_reg_flag;

endmodule

// ===== sv/grid_maze_ray_caster_top.sv =====
// ---------------------------------------------------------------------------
// grid_maze_ray_caster_top
// Maze store plus ray caster: one result per ray of a view request.
// ---------------------------------------------------------------------------
// A write request stores one cell's wall byte. A view request returns
// 2*HALF_FIELD_DEG+1 results, one per ray, lowest offset first, last_ray
// marking the final one. After intake of a view, each ray has its trig
// setup, then steps through every horizontal and vertical grid line, then
// loads the result register, waiting while that register is stalled. A
// line that is parallel or behind is skipped; for any other line the
// shared divider, which yields 4 quotient bits a cycle, finds the offset
// along the line, and for a crossing that falls on the grid it runs again
// for the distance. After reset the maze store is cleared by one pass
// over its GRID_SIDE*GRID_SIDE cells (256 by default), during which
// requests are stalled.
// ---------------------------------------------------------------------------
module grid_maze_ray_caster_top #(
    parameter int GRID_SIDE      = 16,
    parameter int HALF_FIELD_DEG = 30,
    parameter int FRAC_BITS      = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               command,
    input  logic [gmrc_pkg::INDEX_W-1:0]       cell_index,
    input  logic [gmrc_pkg::WALLS_W-1:0]       cell_walls,
    input  logic [gmrc_pkg::POS_W-1:0]         pos_x,
    input  logic [gmrc_pkg::POS_W-1:0]         pos_y,
    input  logic [gmrc_pkg::ANGLE_W-1:0]       view_angle,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [gmrc_pkg::OFF_W-1:0]  ray_offset,
    output logic [gmrc_pkg::OUT_W-1:0]         hit_x,
    output logic [gmrc_pkg::OUT_W-1:0]         hit_y,
    output logic [gmrc_pkg::OUT_W-1:0]         hit_distance,
    output logic [1:0]                         hit_side,
    output logic [gmrc_pkg::CODE_W-1:0]        wall_code,
    output logic                               last_ray
);

    import gmrc_pkg::*;

    localparam int RW = $clog2(2*HALF_FIELD_DEG+1);
    localparam int GW = $clog2(GRID_SIDE+1);
    localparam int AW = $clog2(GRID_SIDE*GRID_SIDE);

    gmrc_cmd_t     cmd;
    gmrc_sts_t     sts;
    logic [RW-1:0] ray;
    logic [GW-1:0] line;
    logic          kind;
    logic [AW-1:0] clr_addr;

    gmrc_ctrl #(
        .GRID_SIDE      (GRID_SIDE),
        .HALF_FIELD_DEG (HALF_FIELD_DEG)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .sts       (sts),
        .cmd       (cmd),
        .ray       (ray),
        .line      (line),
        .kind      (kind),
        .clr_addr  (clr_addr)
    );

    gmrc_dp #(
        .GRID_SIDE      (GRID_SIDE),
        .HALF_FIELD_DEG (HALF_FIELD_DEG),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .ray          (ray),
        .line         (line),
        .kind         (kind),
        .clr_addr     (clr_addr),
        .cell_index   (cell_index),
        .cell_walls   (cell_walls),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .view_angle   (view_angle),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .ray_offset   (ray_offset),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_distance (hit_distance),
        .hit_side     (hit_side),
        .wall_code    (wall_code),
        .last_ray     (last_ray)
    );

    // never overwrite a result that is still waiting
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while stalled");

    // merge and coordinate update only with a finished quotient
    a_merge_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.merge || cmd.other_eval) |-> sts.div_done)
        else $error("quotient used before the divider finished");

    // a new request is only taken while no ray setup, merge or result load is under way
    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !(cmd.merge || cmd.out_load || cmd.ray_setup))
        else $error("request accepted while a view is in progress");

endmodule
